// ===== sv/tkks_pkg.sv =====
// ----------------------------------------------------------------------------
// tkks_pkg
// Shared widths, codes and defaults for the top-k keeper with running sum.
// ----------------------------------------------------------------------------
package tkks_pkg;

  localparam int KEY_W        = 31;   // stored key width
  localparam int CNT_W        = 16;   // query count width
  localparam int SUM_W        = 41;   // running total and result width
  localparam int CAP_W        = 11;   // capacity register width
  localparam int DATA_W       = 32;   // configuration data width
  localparam int ADDR_W       = 2;    // configuration byte address width
  localparam int MAX_KEYS_DEF = 1024; // default store depth

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Register map (byte addresses)
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

endpackage

// ===== sv/tkks_ram.sv =====
// ----------------------------------------------------------------------------
// tkks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkks_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/top_k_keeper_with_sum.sv =====
// ----------------------------------------------------------------------------
// top_k_keeper_with_sum
// Bounded ordered multiset of keys with a running total and top-k sum query.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready. An insert request (opcode 0) adds
//   key_value to the store and gives no result; when the store is full the
//   smallest key is evicted. A query request (opcode 1) returns on
//   out_valid/out_ready the sum of the query_count largest keys, or the
//   running total when query_count reaches the stored count.
//   capacity_limit sits at byte address 0 of the APB port; write it only
//   while the block is idle. Zero acts as one, values above MAX_KEYS as
//   MAX_KEYS. Lowering it trims the store on the next insert.
// Sequencing:
//   One request at a time; in_ready is high only in the idle state. An insert
//   first trims keys left above a lowered capacity; when the store is then full
//   it evicts the smallest key, or drops the new key if it is no larger than the
//   smallest. It then shifts every stored key larger than its key up one slot.
//   A query that sums part of the store adds its largest keys from the top down.
//   Both work on the single store RAM, read one key per cycle.
// Reset: synchronous; clears count and total (no RAM sweep), capacity_limit 1024.
// Stall: a finished result waits in the output register; inserts proceed
//   meanwhile, and a following query holds its result until it is taken.
// ----------------------------------------------------------------------------
module top_k_keeper_with_sum #(
  parameter int MAX_KEYS = tkks_pkg::MAX_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tkks_pkg::ADDR_W-1:0] paddr,
  input  logic [tkks_pkg::DATA_W-1:0] pwdata,
  output logic [tkks_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [tkks_pkg::KEY_W-1:0]  key_value,
  input  logic [tkks_pkg::CNT_W-1:0]  query_count,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tkks_pkg::SUM_W-1:0]  top_sum
);

  import tkks_pkg::*;

  // Store address width and count width (count reaches MAX_KEYS itself)
  localparam int AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW   = $clog2(MAX_KEYS + 1);
  localparam int EW   = (CW > CAP_W) ? CW : CAP_W;
  localparam int QW   = (CW > CNT_W) ? CW : CNT_W;
  localparam int RAMD = 1 << AW;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_PRE       = 8'b0000_0010,  // trim store, pick the insert path
    S_DROP      = 8'b0000_0100,  // evict smallest key
    S_FULL      = 8'b0000_1000,  // store full: compare new key with smallest
    S_INS_PRIME = 8'b0001_0000,  // fetch the largest key
    S_INS_WALK  = 8'b0010_0000,  // shift larger keys up, one per cycle
    S_Q_SUM     = 8'b0100_0000,  // accumulate largest keys, one per cycle
    S_Q_DONE    = 8'b1000_0000   // hand the sum to the output register
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  capacity_limit;
  logic [AW-1:0]     base;       // slot of the smallest key (circular store)
  logic [CW-1:0]     count;
  logic [SUM_W-1:0]  total;
  logic [KEY_W-1:0]  key_reg;
  logic [CW-1:0]     ptr;        // walking offset from base
  logic [CW-1:0]     rem;        // keys still to add for a query
  logic [SUM_W-1:0]  acc;

  logic [EW-1:0]     cap_ext;
  logic [CW-1:0]     cap_eff;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;
  logic              cfg_write;
  logic              shift_up;

  // Map an offset from base onto a physical slot, modulo MAX_KEYS
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] b,
                                         input logic [CW-1:0] o);
    logic [AW:0] s;
    s = {1'b0, b} + {1'b0, o[AW-1:0]};
    if (s >= (AW+1)'(MAX_KEYS)) begin
      s = s - (AW+1)'(MAX_KEYS);
    end
    return s[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == ADDR_CAPACITY) ? DATA_W'(capacity_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_write) begin
      capacity_limit <= pwdata[CAP_W-1:0];
    end
  end

  // Clamp capacity into 1..MAX_KEYS
  always_comb begin
    cap_ext = EW'(capacity_limit);
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > EW'(MAX_KEYS)) begin
      cap_eff = CW'(MAX_KEYS);
    end else begin
      cap_eff = cap_ext[CW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Key store
  // --------------------------------------------------------------------------
  tkks_ram #(
    .WIDTH (KEY_W),
    .DEPTH (RAMD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Walk continues while the fetched neighbor is larger than the new key
  assign shift_up = (ptr != '0) && (ram_rdata > key_reg);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot(base, ptr);
    ram_wdata = key_reg;
    ram_raddr = base;
    case (state)
      S_IDLE: begin
        // prefetch the largest key for a query
        if (count != '0) begin
          ram_raddr = slot(base, count - CW'(1));
        end
      end
      S_INS_PRIME: begin
        if (count != '0) begin
          ram_raddr = slot(base, count - CW'(1));
        end
      end
      S_INS_WALK: begin
        ram_we = 1'b1;
        if (shift_up) begin
          ram_wdata = ram_rdata;
          if (ptr >= CW'(2)) begin
            ram_raddr = slot(base, ptr - CW'(2));
          end
        end
      end
      S_Q_SUM: begin
        ram_raddr = slot(base, ptr);
      end
      default: begin
        ram_raddr = base;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= '0;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result unless a new one is loaded this cycle
      if (out_valid && out_ready && (state != S_Q_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_reg <= key_value;
            if (opcode == OP_INSERT) begin
              state <= S_PRE;
            end else if (QW'(query_count) >= QW'(count)) begin
              acc   <= total;
              state <= S_Q_DONE;
            end else if (query_count == '0) begin
              acc   <= '0;
              state <= S_Q_DONE;
            end else begin
              // largest key is already being read; next read is one below
              acc   <= '0;
              rem   <= CW'(query_count);
              ptr   <= count - CW'(2);
              state <= S_Q_SUM;
            end
          end
        end
        S_PRE: begin
          if (count > cap_eff) begin
            state <= S_DROP;
          end else if (count == cap_eff) begin
            state <= S_FULL;
          end else begin
            state <= S_INS_PRIME;
          end
        end
        S_DROP: begin
          total <= total - SUM_W'(ram_rdata);
          base  <= slot(base, CW'(1));
          count <= count - CW'(1);
          state <= S_PRE;
        end
        S_FULL: begin
          // a new key no larger than the smallest would be evicted at once
          if (key_reg <= ram_rdata) begin
            state <= S_IDLE;
          end else begin
            total <= total - SUM_W'(ram_rdata);
            base  <= slot(base, CW'(1));
            count <= count - CW'(1);
            state <= S_INS_PRIME;
          end
        end
        S_INS_PRIME: begin
          ptr   <= count;
          state <= S_INS_WALK;
        end
        S_INS_WALK: begin
          if (shift_up) begin
            ptr <= ptr - CW'(1);
          end else begin
            count <= count + CW'(1);
            total <= total + SUM_W'(key_reg);
            state <= S_IDLE;
          end
        end
        S_Q_SUM: begin
          acc <= acc + SUM_W'(ram_rdata);
          rem <= rem - CW'(1);
          ptr <= ptr - CW'(1);
          if (rem == CW'(1)) begin
            state <= S_Q_DONE;
          end
        end
        S_Q_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            top_sum   <= acc;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/tkks_checker.sv =====
// ----------------------------------------------------------------------------
// tkks_checker
// Port-level checks for the top-k keeper, bound to the top level.
// ----------------------------------------------------------------------------
module tkks_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       opcode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tkks_pkg::SUM_W-1:0] top_sum
);

  import tkks_pkg::*;

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // Accepting a request drops in_ready, so requests are never taken back to back
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted back to back");

  // An insert never raises a result
  a_insert_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (opcode == OP_INSERT) && !out_valid) |=> !out_valid)
    else $error("result raised by an insert");

  // A stalled result holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(top_sum)))
    else $error("stalled result changed");

endmodule

bind top_k_keeper_with_sum tkks_checker u_tkks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .opcode    (opcode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .top_sum   (top_sum)
);

// ===== verif/top_k_keeper_with_sum_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_keeper_with_sum_checker
// Tracks the ordered key store from accepted requests and checks every sum and capacity readback.
// ----------------------------------------------------------------------------
module top_k_keeper_with_sum_checker #(
  parameter int MAX_KEYS = tkks_pkg::MAX_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tkks_pkg::ADDR_W-1:0] paddr,
  input  logic [tkks_pkg::DATA_W-1:0] pwdata,
  input  logic [tkks_pkg::DATA_W-1:0] prdata,
  input  logic                        pready,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        opcode,
  input  logic [tkks_pkg::KEY_W-1:0]  key_value,
  input  logic [tkks_pkg::CNT_W-1:0]  query_count,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [tkks_pkg::SUM_W-1:0]  top_sum,
  output int                          fail_count,
  output int                          sums_pending,
  output int                          inserts_seen,
  output int                          queries_seen,
  output int                          evictions_seen
);

  import tkks_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [KEY_W-1:0] kept_keys[$];   // ascending
  logic [SUM_W-1:0] kept_total;
  logic [CAP_W-1:0] capacity_reg;
  logic [SUM_W-1:0] sum_fifo[$];
  int               fails;
  int               inserts;
  int               queries;
  int               evictions;

  function automatic int capacity_in_force();
    int c;
    c = int'(capacity_reg);
    if (c == 0) c = 1;
    if (c > MAX_KEYS) c = MAX_KEYS;
    return c;
  endfunction

  function automatic void note_failure(string msg);
    fails++;
    if (fails <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic void evict_smallest();
    kept_total = kept_total - SUM_W'(kept_keys[0]);
    void'(kept_keys.pop_front());
    evictions++;
  endfunction

  function automatic void insert_key(logic [KEY_W-1:0] key);
    int cap;
    int pos;
    cap = capacity_in_force();
    // trim first in case the capacity was lowered while keys were held
    while (kept_keys.size() > cap) evict_smallest();
    pos = kept_keys.size();
    while (pos > 0 && kept_keys[pos-1] > key) pos--;
    kept_keys.insert(pos, key);
    kept_total = kept_total + SUM_W'(key);
    while (kept_keys.size() > cap) evict_smallest();
  endfunction

  function automatic logic [SUM_W-1:0] largest_keys_sum(logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0] s;
    int n;
    n = kept_keys.size();
    if (int'(cnt) >= n) return kept_total;
    s = '0;
    for (int i = 0; i < int'(cnt); i++) s = s + SUM_W'(kept_keys[n-1-i]);
    return s;
  endfunction

  always @(posedge clk) begin
    logic [SUM_W-1:0] want;
    if (rst) begin
      kept_keys.delete();
      sum_fifo.delete();
      kept_total   = '0;
      capacity_reg = CAP_RESET;
    end else begin
      if (psel && penable && pready && paddr == ADDR_CAPACITY) begin
        if (pwrite) begin
          capacity_reg = pwdata[CAP_W-1:0];
        end else if (prdata[CAP_W-1:0] !== capacity_reg) begin
          note_failure($sformatf("capacity readback expected %0d, got %0d",
                                 capacity_reg, prdata[CAP_W-1:0]));
        end
      end
      if (in_valid && in_ready) begin
        if (opcode == OP_INSERT) begin
          inserts++;
          insert_key(key_value);
        end else begin
          queries++;
          sum_fifo.push_back(largest_keys_sum(query_count));
        end
      end
      if (out_valid && out_ready) begin
        if (sum_fifo.size() == 0) begin
          note_failure($sformatf("top_sum %0d with no query outstanding", top_sum));
        end else begin
          want = sum_fifo.pop_front();
          if (top_sum !== want)
            note_failure($sformatf("top_sum expected %0d, got %0d", want, top_sum));
        end
      end
    end
    fail_count     <= fails;
    sums_pending   <= sum_fifo.size();
    inserts_seen   <= inserts;
    queries_seen   <= queries;
    evictions_seen <= evictions;
  end

endmodule

// ===== verif/top_k_keeper_with_sum_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_keeper_with_sum_tb
// Drives insert and query requests and capacity writes into the top-k keeper;
// a side checker predicts every sum and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module top_k_keeper_with_sum_tb;
  import tkks_pkg::*;

  localparam int MAX_KEYS       = MAX_KEYS_DEF;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  // worst single request: shift past the whole store or evict most of it
  localparam int SETTLE_CYCLES  = 2 * MAX_KEYS + 16;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic              opcode;
  logic [KEY_W-1:0]  key_value;
  logic [CNT_W-1:0]  query_count;
  logic              out_valid;
  logic              out_ready;
  logic [SUM_W-1:0]  top_sum;

  int fail_count;
  int sums_pending;
  int inserts_seen;
  int queries_seen;
  int evictions_seen;

  // Idle percentages, changed per phase by the stimulus process.
  int snd_idle_pct;
  int rcv_idle_pct;
  // Capacity in force as far as stimulus cares; used to aim query counts.
  int cap_hint;
  // Long receiver stall: bump hold_reqs to ask for one.
  int hold_reqs;
  int hold_seen;
  int quiet_cycles;

  top_k_keeper_with_sum #(
    .MAX_KEYS(MAX_KEYS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .key_value  (key_value),
    .query_count(query_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .top_sum    (top_sum)
  );

  top_k_keeper_with_sum_checker #(
    .MAX_KEYS(MAX_KEYS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .key_value     (key_value),
    .query_count   (query_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .top_sum       (top_sum),
    .fail_count    (fail_count),
    .sums_pending  (sums_pending),
    .inserts_seen  (inserts_seen),
    .queries_seen  (queries_seen),
    .evictions_seen(evictions_seen)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Result side: take sums at random, or hold off for a long stretch on request
  // so queries back up behind the output register and in_ready drops.
  initial begin
    out_ready <= 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no request or result moved in %0d cycles",
               $realtime, WATCHDOG_LIMIT);
      $display("FAIL top_k_keeper_with_sum");
      $finish;
    end
  end

  // Offer one request; idle first at random, then hold valid and payload
  // until the block takes it.
  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    key_value   <= key;
    query_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every outstanding sum, then let any insert still
  // shifting or evicting finish before the block is touched again.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write capacity_limit (setup then access), then read it back the same way.
  task automatic write_capacity(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cap_hint = (value == 0) ? 1 : ((value > MAX_KEYS) ? MAX_KEYS : value);
  endtask

  // One random phase: new capacity, new idle mix, optional long result stall.
  task automatic random_phase(input int n_items, input int cap, input int snd_pct,
                              input int rcv_pct, input bit long_hold);
    int r;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    write_capacity(cap);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    if (long_hold) hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < n_items; i++) begin
      // keys: mostly full-range, some tiny ones to force duplicates, some edges
      r = $urandom_range(99);
      if (r < 15) key = KEY_W'($urandom_range(7));
      else if (r < 20) key = $urandom_range(1) ? KEY_MAX : '0;
      else key = KEY_W'($urandom);
      // counts: small, around the store size, huge, or anything at all
      r = $urandom_range(99);
      if (r < 30) cnt = CNT_W'($urandom_range(8));
      else if (r < 55) cnt = CNT_W'($urandom_range(cap_hint + 2));
      else if (r < 70) cnt = CNT_W'($urandom_range(65535, 1024));
      else cnt = CNT_W'($urandom);
      if ($urandom_range(99) < 40) send_request(OP_QUERY, key, cnt);
      else send_request(OP_INSERT, key, cnt);
    end
    settle();
  endtask

  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    opcode      <= OP_INSERT;
    key_value   <= '0;
    query_count <= '0;
    hold_reqs   <= 0;
    cap_hint     = MAX_KEYS;
    snd_idle_pct = 36;
    rcv_idle_pct = 85;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, reset capacity ----
    // empty store: zero count and saturated count both give zero
    send_request(OP_QUERY, KEY_W'($urandom), '0);
    send_request(OP_QUERY, KEY_W'($urandom), CNT_MAX);
    // extremes and duplicates
    send_request(OP_INSERT, KEY_MAX, CNT_W'($urandom));
    send_request(OP_INSERT, '0, CNT_W'($urandom));
    send_request(OP_INSERT, KEY_MAX, CNT_W'($urandom));
    send_request(OP_INSERT, KEY_W'(5), CNT_W'($urandom));
    send_request(OP_INSERT, KEY_W'(5), CNT_W'($urandom));
    // zero count, partial sums, count equal to the store, saturated count
    send_request(OP_QUERY, KEY_W'($urandom), '0);
    send_request(OP_QUERY, KEY_W'($urandom), CNT_W'(1));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_W'(2));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_W'(4));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_W'(5));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_MAX);
    settle();

    // lower capacity below the stored count: store stays full until an insert
    write_capacity(2);
    send_request(OP_QUERY, KEY_W'($urandom), CNT_MAX);
    send_request(OP_INSERT, KEY_W'(3), CNT_W'($urandom));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_W'(1));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_MAX);
    settle();

    // capacity zero acts as one
    write_capacity(0);
    send_request(OP_INSERT, KEY_W'(7), CNT_W'($urandom));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_MAX);
    send_request(OP_INSERT, KEY_MAX, CNT_W'($urandom));
    settle();

    // capacity past the store depth clamps to the depth
    write_capacity(2047);
    send_request(OP_INSERT, KEY_W'(1), CNT_W'($urandom));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_W'(1));
    send_request(OP_QUERY, KEY_W'($urandom), CNT_W'(2));
    settle();

    // ---- random part: sender light, receiver heavy idling ----
    random_phase(70, 17, 36, 85, 1'b0);
    random_phase(60, 1, 36, 85, 1'b0);
    // long result stall while requests keep coming
    random_phase(75, 300, 36, 85, 1'b1);
    // ---- sender heavy, receiver light ----
    random_phase(60, 2, 85, 36, 1'b0);
    random_phase(80, 1024, 85, 36, 1'b0);
    random_phase(60, 5, 85, 36, 1'b0);
    // ---- no idling on either side ----
    random_phase(80, 2047, 0, 0, 1'b0);
    random_phase(70, 64, 0, 0, 1'b0);

    $display("Covered %0d inserts, %0d queries and %0d evictions over nine capacity",
             inserts_seen, queries_seen, evictions_seen);
    $display("values, three idle mixes, a long result stall and drains between phases.");
    if (fail_count == 0 && sums_pending == 0) begin
      $display("PASS top_k_keeper_with_sum");
    end else begin
      $display("FAIL top_k_keeper_with_sum");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tkks_pkg.sv
sv/tkks_ram.sv
sv/top_k_keeper_with_sum.sv
sv/tkks_checker.sv
verif/top_k_keeper_with_sum_checker.sv
verif/top_k_keeper_with_sum_tb.sv
